// ===== src/fwrl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the fixed-window rate limiter.
// Depends on nothing; every other file of the block imports it.
package fwrl_pkg;

	localparam int NUM_CLIENTS    = 64;
	localparam int NUM_OPERATIONS = 6;
	localparam int NUM_BUCKETS    = NUM_CLIENTS * NUM_OPERATIONS;
	localparam int BKT_W          = $clog2(NUM_BUCKETS);
	localparam int OP_IDX_W       = (NUM_OPERATIONS > 1) ? $clog2(NUM_OPERATIONS) : 1;

	localparam int CLIENT_W = 6;
	localparam int OP_W     = 3;
	localparam int TIME_W   = 48;
	localparam int CNT_W    = 48;
	localparam int REQ_W    = 16;
	localparam int WIN_W    = 32;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	localparam logic [REQ_W-1:0] MIN_REQUESTS   = REQ_W'(1);
	localparam logic [WIN_W-1:0] MIN_WINDOW     = WIN_W'(1000);
	localparam logic [REQ_W-1:0] RESET_REQUESTS = REQ_W'(60);
	localparam logic [WIN_W-1:0] RESET_WINDOW   = WIN_W'(60000);

	// Register select, taken from address bit 2.
	localparam logic REG_MAX_REQUESTS = 1'b0;
	localparam logic REG_WINDOW_MS    = 1'b1;

	// One queued request after classification.
	typedef struct packed {
		logic                bad;
		logic [BKT_W-1:0]    bucket;
		logic [OP_IDX_W-1:0] op;
		logic [TIME_W-1:0]   now;
	} req_t;

	// One bucket memory entry.
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] start;
		logic [REQ_W-1:0]  count;
	} bucket_t;

	// One result as driven onto the output ports.
	typedef struct packed {
		logic             accepted;
		logic [WIN_W-1:0] retry;
		logic [CNT_W-1:0] op_acc;
		logic [CNT_W-1:0] op_rej;
		logic [CNT_W-1:0] all_acc;
		logic [CNT_W-1:0] all_rej;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIFF,
		B_DEC,
		B_WB
	} back_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== src/fwrl_front.sv =====
`timescale 1ns / 1ps
// Front end: takes a request, checks its indices and forms the bucket address.
// Depends on fwrl_pkg.
module fwrl_front (
	input  logic                          start,
	input  logic [fwrl_pkg::CLIENT_W-1:0] client_index,
	input  logic [fwrl_pkg::OP_W-1:0]     operation,
	input  logic [fwrl_pkg::TIME_W-1:0]   now_ms,
	input  logic                          q_full,
	input  logic                          clearing,
	output logic                          busy,
	output logic                          push,
	output fwrl_pkg::req_t                push_data
);
	import fwrl_pkg::*;

	logic in_range;

	assign busy     = q_full || clearing;
	assign push     = start && !busy;
	assign in_range = (32'(client_index) < NUM_CLIENTS) && (32'(operation) < NUM_OPERATIONS);

	// Out-of-range requests carry address zero so that no read leaves the memory.
	always_comb begin
		push_data.bad = !in_range;
		push_data.now = now_ms;
		if (in_range) begin
			push_data.bucket = BKT_W'(32'(client_index) * NUM_OPERATIONS + 32'(operation));
			push_data.op     = OP_IDX_W'(operation);
		end else begin
			push_data.bucket = '0;
			push_data.op     = '0;
		end
	end

endmodule

// ===== src/fwrl_queue.sv =====
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
// Depends on fwrl_pkg.
module fwrl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fwrl_pkg::req_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output fwrl_pkg::req_t head
);
	import fwrl_pkg::*;

	req_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/fwrl_back.sv =====
`timescale 1ns / 1ps
// Back end: bucket memory, window decision, saturating counters and result register.
// Depends on fwrl_pkg.
module fwrl_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  fwrl_pkg::req_t             q_head,
	output logic                       q_pop,
	input  logic [fwrl_pkg::REQ_W-1:0] max_requests,
	input  logic [fwrl_pkg::WIN_W-1:0] window_ms,
	input  logic                       clear_req,
	output logic                       clearing,
	output logic                       done,
	output fwrl_pkg::result_t          result
);
	import fwrl_pkg::*;

	back_state_t state_q, state_d;

	req_t              cur_q;
	bucket_t           rd_data_q;
	logic [TIME_W:0]   diff_q;
	logic              acc_q;
	logic [WIN_W-1:0]  retry_q;
	logic [REQ_W-1:0]  new_count_q;
	logic [TIME_W-1:0] new_start_q;

	bucket_t          mem [NUM_BUCKETS];
	logic             mem_we;
	logic [BKT_W-1:0] mem_waddr;
	bucket_t          mem_wdata;

	logic             clr_active_q;
	logic [BKT_W-1:0] clr_addr_q;

	logic [CNT_W-1:0] per_op_acc_q [NUM_OPERATIONS];
	logic [CNT_W-1:0] per_op_rej_q [NUM_OPERATIONS];
	logic [CNT_W-1:0] sum_acc_q, sum_rej_q;

	logic             expired;
	logic [REQ_W-1:0] eff_count;
	logic [WIN_W-1:0] elapsed;
	logic             acc_d;
	logic             commit;
	logic [CNT_W-1:0] op_acc_cur, op_rej_cur;
	logic [CNT_W-1:0] op_acc_nxt, op_rej_nxt, sum_acc_nxt, sum_rej_nxt;

	logic    done_flag_q;
	result_t res_q;

	assign done     = done_flag_q;
	assign result   = res_q;
	assign clearing = clr_active_q;

	// Sequencer: pop, subtract, decide, write back (a bad request skips to write
	// back). A pop on the write-back edge starts the next request at once.
	always_comb begin
		q_pop   = 1'b0;
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty && !clr_active_q) begin
					q_pop   = 1'b1;
					state_d = q_head.bad ? B_WB : B_DIFF;
				end
			end
			B_DIFF: state_d = B_DEC;
			B_DEC:  state_d = B_WB;
			B_WB: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = q_head.bad ? B_WB : B_DIFF;
				end else begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window decision. A bucket that is unused, has time running backwards or
	// has run out its window restarts at the current time with a count of zero.
	always_comb begin
		expired   = !rd_data_q.valid || diff_q[TIME_W] ||
		            (diff_q[TIME_W-1:0] >= TIME_W'(window_ms));
		eff_count = expired ? '0 : rd_data_q.count;
		elapsed   = expired ? '0 : diff_q[WIN_W-1:0];
		acc_d     = (eff_count < max_requests);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (state_q == B_DIFF) begin
			diff_q <= {1'b0, cur_q.now} - {1'b0, rd_data_q.start};
		end
		if (state_q == B_DEC) begin
			acc_q       <= acc_d;
			retry_q     <= acc_d ? '0 : window_ms - elapsed;
			new_count_q <= acc_d ? eff_count + 1'b1 : eff_count;
			new_start_q <= expired ? cur_q.now : rd_data_q.start;
		end
	end

	// Bucket memory. A read on the same edge as a write to the same entry
	// takes the new data, so back-to-back hits on one bucket see the update.
	assign commit = (state_q == B_WB) && !cur_q.bad;

	always_comb begin
		mem_we = clr_active_q || commit;
		if (clr_active_q) begin
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_waddr = cur_q.bucket;
			mem_wdata = '{valid: 1'b1, start: new_start_q, count: new_count_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (q_pop) begin
			rd_data_q <= (mem_we && mem_waddr == q_head.bucket) ? mem_wdata : mem[q_head.bucket];
		end
	end

	// Clearing pass over every entry, after reset and after each register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clear_req) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			if (clr_addr_q == BKT_W'(NUM_BUCKETS - 1)) begin
				clr_active_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Counters.
	always_comb begin
		op_acc_cur  = per_op_acc_q[cur_q.op];
		op_rej_cur  = per_op_rej_q[cur_q.op];
		op_acc_nxt  = acc_q ? sat_inc(op_acc_cur) : op_acc_cur;
		op_rej_nxt  = acc_q ? op_rej_cur : sat_inc(op_rej_cur);
		sum_acc_nxt = acc_q ? sat_inc(sum_acc_q) : sum_acc_q;
		sum_rej_nxt = acc_q ? sum_rej_q : sat_inc(sum_rej_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_OPERATIONS; i++) begin
				per_op_acc_q[i] <= '0;
				per_op_rej_q[i] <= '0;
			end
			sum_acc_q <= '0;
			sum_rej_q <= '0;
		end else if (commit) begin
			per_op_acc_q[cur_q.op] <= op_acc_nxt;
			per_op_rej_q[cur_q.op] <= op_rej_nxt;
			sum_acc_q              <= sum_acc_nxt;
			sum_rej_q              <= sum_rej_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_flag_q <= 1'b0;
		end else begin
			done_flag_q <= (state_q == B_WB);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_WB) begin
			if (cur_q.bad) begin
				res_q <= '{accepted: 1'b0, retry: '0, op_acc: '0, op_rej: '0,
				           all_acc: sum_acc_q, all_rej: sum_rej_q};
			end else begin
				res_q <= '{accepted: acc_q, retry: retry_q, op_acc: op_acc_nxt,
				           op_rej: op_rej_nxt, all_acc: sum_acc_nxt, all_rej: sum_rej_nxt};
			end
		end
	end

endmodule

// ===== src/fixed_window_rate_limiter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the fixed-window rate limiter: register port, front end, queue, back end.
// Depends on fwrl_pkg, fwrl_front, fwrl_queue and fwrl_back.
//
//  channel    handshake                        payload
//  ---------  -------------------------------  ------------------------------------------
//  request    start & !busy                    client_index, operation, now_ms
//  result     done (one cycle, no backpressure) accepted, retry_after_ms, four totals
//  registers  psel & penable & pwrite & pready paddr, pwdata (prdata on reads)
//
// A request is taken into a two-entry queue on the edge where start is high and busy
// is low. The back end works on one request at a time (subtract, decide, write back),
// a limit set by the single bucket memory port and its read-modify-write; the queue
// takes new requests while it has room. With the back end idle, a normal request
// passes the queue, the pop, the subtract, decide and write-back states and the done
// register; one with an out-of-range index goes from the pop straight to write back.
// After reset and after every register write the bucket memory is swept over all its
// entries, one entry a cycle, and busy stays high during the sweep. Results cannot be
// held off by the receiver; done marks each for exactly one cycle.
module fixed_window_rate_limiter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fwrl_pkg::ADDR_W-1:0]   paddr,
	input  logic [fwrl_pkg::DATA_W-1:0]   pwdata,
	output logic [fwrl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// request channel
	input  logic                          start,
	output logic                          busy,
	input  logic [fwrl_pkg::CLIENT_W-1:0] client_index,
	input  logic [fwrl_pkg::OP_W-1:0]     operation,
	input  logic [fwrl_pkg::TIME_W-1:0]   now_ms,
	// result channel
	output logic                          done,
	output logic                          accepted,
	output logic [fwrl_pkg::WIN_W-1:0]    retry_after_ms,
	output logic [fwrl_pkg::CNT_W-1:0]    op_accepted_total,
	output logic [fwrl_pkg::CNT_W-1:0]    op_rejected_total,
	output logic [fwrl_pkg::CNT_W-1:0]    all_accepted_total,
	output logic [fwrl_pkg::CNT_W-1:0]    all_rejected_total
);
	import fwrl_pkg::*;

	logic [REQ_W-1:0] max_req_q;
	logic [WIN_W-1:0] window_q;
	logic             cfg_wr;
	logic             reg_sel;

	logic    q_push, q_pop, q_full, q_empty;
	req_t    q_push_data, q_head;
	logic    clearing;
	result_t result;

	// Register port. Writes are clamped to the minimum legal values and each
	// write restarts the clearing sweep so that every bucket opens a new window.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q <= RESET_REQUESTS;
			window_q  <= RESET_WINDOW;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_MAX_REQUESTS: begin
					max_req_q <= (pwdata[REQ_W-1:0] < MIN_REQUESTS) ? MIN_REQUESTS
					                                                : pwdata[REQ_W-1:0];
				end
				REG_WINDOW_MS: begin
					window_q <= (pwdata[WIN_W-1:0] < MIN_WINDOW) ? MIN_WINDOW
					                                             : pwdata[WIN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MAX_REQUESTS: prdata = DATA_W'(max_req_q);
			REG_WINDOW_MS:    prdata = DATA_W'(window_q);
			default:          prdata = '0;
		endcase
	end

	// The front end classifies each request and hands it to the queue.
	fwrl_front u_front (
		.start       (start),
		.client_index(client_index),
		.operation   (operation),
		.now_ms      (now_ms),
		.q_full      (q_full),
		.clearing    (clearing),
		.busy        (busy),
		.push        (q_push),
		.push_data   (q_push_data)
	);

	fwrl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_push_data),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (q_head)
	);

	// The back end owns the bucket memory and all counters.
	fwrl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.max_requests(max_req_q),
		.window_ms   (window_q),
		.clear_req   (cfg_wr),
		.clearing    (clearing),
		.done        (done),
		.result      (result)
	);

	assign accepted           = result.accepted;
	assign retry_after_ms     = result.retry;
	assign op_accepted_total  = result.op_acc;
	assign op_rejected_total  = result.op_rej;
	assign all_accepted_total = result.all_acc;
	assign all_rejected_total = result.all_rej;

	// An accepted request never carries a retry delay.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> retry_after_ms == '0)
		else $error("accepted result with nonzero retry delay");

	// An accepted request has been counted in both its operation and the total.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> op_accepted_total != '0 && all_accepted_total != '0)
		else $error("accepted result with a zero accepted count");

	// A request rejected by the limit always has time left in its window.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted && op_rejected_total != '0 |-> retry_after_ms != '0)
		else $error("rate-limited result with zero retry delay");

	// The queue is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("request queue overflow");

endmodule
